/* sv/crv_pkg.sv */
package crv_pkg;

    localparam int MAX_PAYLOAD = 256;
    localparam int HDR_BYTES   = 12;
    localparam int TAIL_BYTES  = 4;
    localparam int MAX_RECORD  = HDR_BYTES + MAX_PAYLOAD + TAIL_BYTES;
    localparam int CNT_W       = $clog2(MAX_RECORD + 2);
    localparam int SUM_W       = 17;

    localparam logic [31:0] REC_MAGIC = 32'h3147_5343;
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [15:0] MIN_VERSION     = 16'd1;
    localparam logic [15:0] MAX_VERSION_RST = 16'd3;
    localparam logic [15:0] MIN_PAYLOAD_RST = 16'd24;

    localparam int OUT_W = 72;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_TOTAL    = 3'd1,
        ERR_MAGIC    = 3'd2,
        ERR_VERSION  = 3'd3,
        ERR_MISMATCH = 3'd4,
        ERR_RANGE    = 3'd5,
        ERR_HASH     = 3'd6
    } err_code_t;

    typedef enum logic [0:0] {
        REG_MAX_VERSION = 1'b0,
        REG_MIN_PAYLOAD = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [31:0]      magic;
        logic [15:0]      version;
        logic [15:0]      length;
        logic [31:0]      seq_num;
        logic [31:0]      hash;
        logic [31:0]      tail;
    } record_snap_t;

endpackage

/* sv/checked_record_validator_top.sv */
// Checks stored save records that arrive one byte per transfer on the s_ stream, with
// s_tlast on the final byte. One byte is taken every cycle; s_tready drops only while a
// finished verdict waits both in the check stage and in the output register. Each
// accepted byte updates the header fields and the FNV-1a hash (one 32x32 constant
// multiply); the final byte's state is captured and checked in the check stage, and
// the verdict moves to the output register on m_ when it is empty or read. Bytes that
// are not final produce no result. Registers: max_version at 0x0, min_payload at 0x4;
// write them only while no record is in flight.
module checked_record_validator_top import crv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // tdata: data_byte[7:0]
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              s_tvalid,
    output logic              s_tready,
    // tdata: record_ok[0], error_code[3:1], sequence_res[35:4], format_version[51:36],
    //        payload_length[67:52], zero[71:68]
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORD);

    logic [15:0] max_version_reg;
    logic [15:0] min_payload_reg;

    logic [CNT_W-1:0] count_reg,    count_next;
    logic [31:0]      magic_reg,    magic_next;
    logic [15:0]      version_reg,  version_next;
    logic [15:0]      length_reg,   length_next;
    logic [31:0]      sequence_reg, sequence_next;
    logic [31:0]      hash_reg,     hash_next;
    logic [31:0]      tail_reg,     tail_next;
    logic [31:0]      hash_mix;
    logic [31:0]      hash_prod;

    record_snap_t     snap_reg;
    logic             snap_valid_reg, snap_valid_next;
    logic             snap_advance;

    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic             out_valid_reg, out_valid_next;

    logic             s_accept;
    logic             cfg_write;
    reg_index_t       cfg_index;
    err_code_t        code;
    logic [SUM_W-1:0] expect_len;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb begin
        case (cfg_index)
            REG_MAX_VERSION: prdata = {16'd0, max_version_reg};
            REG_MIN_PAYLOAD: prdata = {16'd0, min_payload_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_version_reg <= MAX_VERSION_RST;
            min_payload_reg <= MIN_PAYLOAD_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_MAX_VERSION: max_version_reg <= pwdata[15:0];
                REG_MIN_PAYLOAD: min_payload_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign snap_advance = !out_valid_reg || m_tready;
    assign s_tready     = !snap_valid_reg || snap_advance;
    assign s_accept     = s_tvalid && s_tready;

    // byte update: header assembly, hash of the byte leaving the tail window
    always_comb begin
        magic_next    = magic_reg;
        version_next  = version_reg;
        length_next   = length_reg;
        sequence_next = sequence_reg;
        if (count_reg < CNT_W'(4)) begin
            magic_next[{count_reg[1:0], 3'b000} +: 8] = s_tdata;
        end else if (count_reg < CNT_W'(6)) begin
            version_next[{count_reg[0], 3'b000} +: 8] = s_tdata;
        end else if (count_reg < CNT_W'(8)) begin
            length_next[{count_reg[0], 3'b000} +: 8] = s_tdata;
        end else if (count_reg < CNT_W'(HDR_BYTES)) begin
            sequence_next[{count_reg[1:0], 3'b000} +: 8] = s_tdata;
        end

        hash_mix  = hash_reg ^ {24'd0, tail_reg[7:0]};
        hash_prod = hash_mix * FNV_PRIME;
        hash_next = (count_reg >= CNT_W'(TAIL_BYTES)) ? hash_prod : hash_reg;
        tail_next = {s_tdata, tail_reg[31:8]};
        count_next = (count_reg <= CNT_MAX) ? count_reg + CNT_W'(1) : count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            magic_reg    <= '0;
            version_reg  <= '0;
            length_reg   <= '0;
            sequence_reg <= '0;
            hash_reg     <= FNV_BASIS;
            tail_reg     <= '0;
        end else if (s_accept) begin
            if (s_tlast) begin
                count_reg    <= '0;
                magic_reg    <= '0;
                version_reg  <= '0;
                length_reg   <= '0;
                sequence_reg <= '0;
                hash_reg     <= FNV_BASIS;
                tail_reg     <= '0;
            end else begin
                count_reg    <= count_next;
                magic_reg    <= magic_next;
                version_reg  <= version_next;
                length_reg   <= length_next;
                sequence_reg <= sequence_next;
                hash_reg     <= hash_next;
                tail_reg     <= tail_next;
            end
        end
    end

    // capture the final state of a record for checking
    always_ff @(posedge aclk) begin
        if (s_accept && s_tlast) begin
            snap_reg.count   <= count_next;
            snap_reg.magic   <= magic_next;
            snap_reg.version <= version_next;
            snap_reg.length  <= length_next;
            snap_reg.seq_num <= sequence_next;
            snap_reg.hash    <= hash_next;
            snap_reg.tail    <= tail_next;
        end
    end

    always_comb begin
        if (s_accept && s_tlast) begin
            snap_valid_next = 1'b1;
        end else if (snap_advance) begin
            snap_valid_next = 1'b0;
        end else begin
            snap_valid_next = snap_valid_reg;
        end
    end

    assign expect_len = {1'b0, snap_reg.length} + SUM_W'(HDR_BYTES + TAIL_BYTES);

    always_comb begin
        if (snap_reg.count < CNT_W'(HDR_BYTES + TAIL_BYTES) || snap_reg.count > CNT_MAX) begin
            code = ERR_TOTAL;
        end else if (snap_reg.magic != REC_MAGIC) begin
            code = ERR_MAGIC;
        end else if (snap_reg.version < MIN_VERSION || snap_reg.version > max_version_reg) begin
            code = ERR_VERSION;
        end else if (expect_len != SUM_W'(snap_reg.count)) begin
            code = ERR_MISMATCH;
        end else if (snap_reg.length > 16'(MAX_PAYLOAD) || snap_reg.length < min_payload_reg) begin
            code = ERR_RANGE;
        end else if (snap_reg.tail != snap_reg.hash) begin
            code = ERR_HASH;
        end else begin
            code = ERR_OK;
        end
        out_data_next = {4'd0, snap_reg.length, snap_reg.version, snap_reg.seq_num,
                         code, (code == ERR_OK)};
    end

    always_comb begin
        if (snap_valid_reg && snap_advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            snap_valid_reg <= snap_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid_reg && snap_advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX + CNT_W'(1))
        else $error("byte count past saturation");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (snap_valid_reg && count_reg == '0 && hash_reg == FNV_BASIS))
        else $error("final byte did not capture and clear the record");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (snap_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a waiting verdict");

    a_snap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid_reg && !snap_advance) |=> (snap_valid_reg && $stable(snap_reg)))
        else $error("pending verdict state changed while stalled");
`endif

endmodule
